// File: rtl/core/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg: shared constants and helpers for the signed integer to text block
// Character codes, radix limits and the per-cycle width of the digit divider.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 32;   // default width of the signed input value
    localparam int RADIX_W        = 6;    // width of the radix field
    localparam int DIV_BITS       = 4;    // quotient bits resolved per divider cycle

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_SEVEN = 8'h37;  // '7', so '7' + 10 lands on 'A'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;  // 'Z'

    localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

    // Pull an out-of-range radix back into 2..36.
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r inside {[6'd0 : 6'd1]})
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        return res;
    endfunction

    // Digit value 0..35 to its character, '0'..'9' then 'A'..'Z'.
    function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [7:0] res;
        if (d < DIGIT_TEN)
            res = CH_ZERO + {2'b00, d};
        else
            res = CH_SEVEN + {2'b00, d};
        return res;
    endfunction

endpackage

// File: rtl/core/signed_int_to_ascii_radix_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_ascii_radix_top: signed integer to ASCII text in radix 2..36
// Converts one signed value per request into a stream of characters.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one request carries the signed value and the radix.
//   The radix is clamped into 2..36. s_tready is high only while the block
//   is idle; a request is taken when s_tvalid and s_tready are both high.
//   Master channel (m_*): one character per transfer, '-' first for a
//   negative value, then the digits most significant first ('A'..'Z' above
//   nine). m_tlast marks the final character. Zero gives a single "0".
// Operation:
//   Digits come from a shared shift-subtract divider that resolves four
//   quotient bits a cycle, least significant digit first. Digits are
//   parked in a small digit memory, then read back in reverse, each
//   character passing through a read state and a load state; the sign
//   goes out first, from its own state. A new request is accepted only
//   once the block is back in idle after the last character is issued.
// Reset and stalls:
//   rst_n clears the sequencer state and the output valid flag. While the
//   receiver stalls, m_tvalid and the character hold; the sequencer waits in its sign or load state.
// ----------------------------------------------------------------------------
module signed_int_to_ascii_radix_top #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // s_tdata fields, lowest bit up: value[VALUE_BITS], radix[6], zero fill
    input  logic [((VALUE_BITS+itoa_pkg::RADIX_W+7)/8)*8-1:0] s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // m_tdata fields, lowest bit up: ch[8]
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready
);
    import itoa_pkg::*;

    localparam int MAG_W     = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS = MAG_W / DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int IDX_W     = $clog2(VALUE_BITS);
    localparam int CNT_W     = $clog2(VALUE_BITS + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SIGN = 5'b00100,
        ST_READ = 5'b01000,
        ST_LOAD = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic [RADIX_W-1:0]   rem_reg, rem_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic                 neg_reg, neg_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]     nd_reg, nd_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [7:0]           rd_data_reg;
    logic [7:0]           m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [7:0]           digit_mem [VALUE_BITS];

    logic [VALUE_BITS-1:0] in_value;
    logic [VALUE_BITS-1:0] in_neg_value;
    logic [RADIX_W-1:0]    in_radix;
    logic                  in_neg;
    logic [MAG_W-1:0]      in_mag;

    // divider datapath
    logic [RADIX_W:0]     div_r;
    logic [MAG_W-1:0]     div_q;
    logic                 last_step;
    logic                 digit_wr;
    logic                 out_free;

    assign in_value     = s_tdata[VALUE_BITS-1:0];
    assign in_radix     = s_tdata[VALUE_BITS+RADIX_W-1:VALUE_BITS];
    assign in_neg       = in_value[VALUE_BITS-1];
    assign in_neg_value = ~in_value + {{(VALUE_BITS-1){1'b0}}, 1'b1};
    assign in_mag       = MAG_W'(in_neg ? in_neg_value : in_value);

    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_step = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign digit_wr  = (state_reg == ST_DIV) && last_step;

    // Four restoring shift-subtract steps on the narrow remainder.
    always_comb
    begin
        div_r = {1'b0, rem_reg};
        div_q = mag_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            div_r = {div_r[RADIX_W-1:0], div_q[MAG_W-1]};
            div_q = {div_q[MAG_W-2:0], 1'b0};
            if (div_r >= {1'b0, radix_reg})
            begin
                div_r    = div_r - {1'b0, radix_reg};
                div_q[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        radix_next    = radix_reg;
        neg_next      = neg_reg;
        step_next     = step_reg;
        nd_next       = nd_reg;
        rd_idx_next   = rd_idx_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mag_next   = in_mag;
                    rem_next   = '0;
                    radix_next = clamp_radix(in_radix);
                    neg_next   = in_neg;
                    step_next  = '0;
                    nd_next    = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                mag_next = div_q;
                rem_next = div_r[RADIX_W-1:0];
                if (last_step)
                begin
                    // digit done: restart on the quotient or start emitting
                    step_next   = '0;
                    rem_next    = '0;
                    nd_next     = nd_reg + CNT_W'(1);
                    rd_idx_next = nd_reg[IDX_W-1:0];
                    if (div_q == '0)
                        state_next = neg_reg ? ST_SIGN : ST_READ;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CH_MINUS;
                    m_tlast_next  = 1'b0;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rd_data_reg;
                    m_tlast_next  = (rd_idx_reg == '0);
                    if (rd_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - IDX_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        rem_reg     <= rem_next;
        radix_reg   <= radix_next;
        neg_reg     <= neg_next;
        step_reg    <= step_next;
        nd_reg      <= nd_next;
        rd_idx_reg  <= rd_idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Digit memory: least significant digit at address zero.
    always_ff @(posedge clk)
    begin
        if (digit_wr)
            digit_mem[nd_reg[IDX_W-1:0]] <= digit_char(div_r[RADIX_W-1:0]);
        if (state_reg == ST_READ)
            rd_data_reg <= digit_mem[rd_idx_reg];
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

// File: rtl/core/itoa_checker.sv
// ----------------------------------------------------------------------------
// itoa_checker: port-level checks for the signed integer to text block
// Watches the request and character channels over time.
// ----------------------------------------------------------------------------
module itoa_checker #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic [((VALUE_BITS+itoa_pkg::RADIX_W+7)/8)*8-1:0] s_tdata,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [7:0]             m_tdata,
    input logic                   m_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready
);
    import itoa_pkg::*;

    // a stalled character holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("character changed while stalled");

    // a taken request starts a conversion
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after a request");

    // more characters pending means the block is still busy
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken before text finished");

    // the sign never ends the text
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == CH_MINUS) |-> !m_tlast)
        else $error("sign marked as last character");

    // only sign, digits and capitals appear
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == CH_MINUS)
                  || (m_tdata >= CH_ZERO && m_tdata <= CH_NINE)
                  || (m_tdata >= CH_UPPER_A && m_tdata <= CH_UPPER_Z))
        else $error("character outside the digit set");

endmodule

bind signed_int_to_ascii_radix_top itoa_checker #(.VALUE_BITS(VALUE_BITS)) u_itoa_checker (.*);
